FILE: rtl/core/pli_pkg.sv
// Package: shared types, codes and sizes of the piecewise linear interpolator.
`timescale 1ns / 1ps
package pli_pkg;
  localparam int unsigned MaxNodesDef = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned TotalW      = 5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOR  = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0,
    MD_MUL  = 2'd1,
    MD_DIV  = 2'd2,
    MD_SUM  = 2'd3
  } md_state_e;

  // Compare flags one cell reports against the request abscissa.
  typedef struct packed {
    logic gt;  // valid node, node x above request x
    logic le;  // valid node, node x at or below request x
    logic lt;  // valid node, node x below request x
    logic eq;  // valid node, node x equal to request x
  } cell_flags_t;
endpackage

FILE: rtl/core/pli_cell.sv
// One table cell: holds a node and shifts it right on a sorted insert.
`timescale 1ns / 1ps
module pli_cell
  import pli_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     valid_i,
  input  logic                     tail_i,
  input  logic                     ins_en_i,
  input  logic signed [CoordW-1:0] req_x_i,
  input  logic signed [CoordW-1:0] req_y_i,
  input  logic signed [CoordW-1:0] prev_x_i,
  input  logic signed [CoordW-1:0] prev_y_i,
  input  logic                     prev_gt_i,
  output logic signed [CoordW-1:0] x_o,
  output logic signed [CoordW-1:0] y_o,
  output cell_flags_t              flags_o
);
  logic signed [CoordW-1:0] x_q, x_d, y_q, y_d;

  always_comb begin
    flags_o.gt = valid_i && (x_q > req_x_i);
    flags_o.le = valid_i && (x_q <= req_x_i);
    flags_o.lt = valid_i && (x_q < req_x_i);
    flags_o.eq = valid_i && (x_q == req_x_i);
    x_d = x_q;
    y_d = y_q;
    if (ins_en_i) begin
      if (prev_gt_i) begin
        x_d = prev_x_i;
        y_d = prev_y_i;
      end else if (flags_o.gt || tail_i) begin
        x_d = req_x_i;
        y_d = req_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
endmodule

FILE: rtl/core/pli_muldiv.sv
// Shift-add multiplier followed by restoring divider and saturating add.
`timescale 1ns / 1ps
module pli_muldiv
  import pli_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CoordW:0]          mag_i,
  input  logic                     neg_i,
  input  logic [CoordW-1:0]        off_i,
  input  logic [CoordW-1:0]        dx_i,
  input  logic signed [CoordW-1:0] y0_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [CoordW-1:0] result_o
);
  localparam int unsigned AccW = 2 * CoordW + 1;
  localparam int unsigned SumW = CoordW + 3;
  localparam logic [6:0] MulLast = 7'(CoordW - 1);
  localparam logic [6:0] DivLast = 7'(AccW - 1);

  md_state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CoordW-1:0] rem_q, rem_d, off_q, off_d, dx_q, dx_d;
  logic [CoordW:0] mag_q, mag_d, rem_sh;
  logic neg_q, neg_d;
  logic signed [CoordW-1:0] y0_q, y0_d, res_q, res_d;
  logic signed [SumW-1:0] sum;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    off_d   = off_q;
    dx_d    = dx_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    y0_d    = y0_q;
    res_d   = res_q;
    done_d  = 1'b0;
    rem_sh  = {rem_q, acc_q[AccW-1]};
    sum     = '0;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          mag_d   = mag_i;
          neg_d   = neg_i;
          off_d   = off_i;
          dx_d    = dx_i;
          y0_d    = y0_i;
          acc_d   = '0;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_d = {acc_q[AccW-2:0], 1'b0}
                + (off_q[CoordW-1] ? AccW'(mag_q) : '0);
        off_d = {off_q[CoordW-2:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        if (rem_sh >= {1'b0, dx_q}) begin
          rem_d = CoordW'(rem_sh - {1'b0, dx_q});
          acc_d = {acc_q[AccW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[CoordW-1:0];
          acc_d = {acc_q[AccW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DivLast) state_d = MD_SUM;
      end
      MD_SUM: begin
        // quotient stays below the slope magnitude, so 33 bits hold it
        if (neg_q) sum = SumW'(y0_q) - $signed({2'b00, acc_q[CoordW:0]});
        else       sum = SumW'(y0_q) + $signed({2'b00, acc_q[CoordW:0]});
        if (sum > $signed(SumW'({1'b0, {(CoordW-1){1'b1}}})))
          res_d = {1'b0, {(CoordW-1){1'b1}}};
        else if (sum < -$signed(SumW'({1'b1, {(CoordW-1){1'b0}}})))
          res_d = {1'b1, {(CoordW-1){1'b0}}};
        else
          res_d = sum[CoordW-1:0];
        done_d  = 1'b1;
        state_d = MD_IDLE;
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    off_q <= off_d;
    dx_q  <= dx_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    y0_q  <= y0_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q != MD_IDLE) || done_q;
  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

FILE: rtl/core/piecewise_linear_interpolator_core.sv
// Top level: node table as a chain of cells, segment select and interpolation.
// Clear, insert and in-table or out-of-range queries: the result is registered and
// shows in the cycle after acceptance. Interpolating queries first run through the
// bit-serial multiplier, the restoring divider and the saturating add.
// One request at a time: a new one is taken only once the last result has left.
// Reset (async, active low) empties the table; node storage is not cleared.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_core
  import pli_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [CoordW-1:0] x_coord_i,
  input  logic signed [CoordW-1:0] y_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [CoordW-1:0] result_value_o,
  output logic [TotalW-1:0]        node_total_o
);
  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_NODES);

  logic [CntW-1:0] count_q, count_d;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic signed [CoordW-1:0] result_q, result_d;

  logic accept, ins_en, md_start, md_busy, md_done;
  logic signed [CoordW-1:0] md_result;

  logic signed [CoordW-1:0] cx [MAX_NODES];
  logic signed [CoordW-1:0] cy [MAX_NODES];
  cell_flags_t              cf [MAX_NODES];
  logic [MAX_NODES-1:0]     valid, tail, sel, last;

  assign accept = in_valid_i && in_ready_o;
  // Take a new request only with the arithmetic unit idle and the output free.
  assign in_ready_o = !busy_q && !out_valid_q;

  // Chain of node cells; each cell passes its node to the right on insert.
  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    logic signed [CoordW-1:0] px, py;
    logic pgt;
    if (k == 0) begin : g_head
      assign px  = '0;
      assign py  = '0;
      assign pgt = 1'b0;
    end else begin : g_link
      assign px  = cx[k-1];
      assign py  = cy[k-1];
      assign pgt = cf[k-1].gt;
    end
    assign valid[k] = (CntW'(k) < count_q);
    assign tail[k]  = (CntW'(k) == count_q);
    assign last[k]  = (CntW'(k + 1) == count_q);
    pli_cell u_cell (
      .clk_i     (clk_i),
      .valid_i   (valid[k]),
      .tail_i    (tail[k]),
      .ins_en_i  (ins_en),
      .req_x_i   (x_coord_i),
      .req_y_i   (y_value_i),
      .prev_x_i  (px),
      .prev_y_i  (py),
      .prev_gt_i (pgt),
      .x_o       (cx[k]),
      .y_o       (cy[k]),
      .flags_o   (cf[k])
    );
    // Segment start: last node at or below the argument.
    if (k == MAX_NODES - 1) begin : g_sel_end
      assign sel[k] = cf[k].le;
    end else begin : g_sel
      assign sel[k] = cf[k].le && !cf[k+1].le;
    end
  end

  // Pick the segment's two nodes with an AND-OR select over the one-hot row.
  logic signed [CoordW-1:0] x0, y0, x1, y1;
  logic dup, above, at_end, hit;
  always_comb begin
    x0 = '0; y0 = '0; x1 = '0; y1 = '0;
    dup = 1'b0; above = 1'b0; at_end = 1'b0; hit = 1'b0;
    for (int k = 0; k < MAX_NODES; k++) begin
      dup   |= cf[k].eq;
      above |= last[k] && cf[k].lt;
      if (sel[k]) begin
        x0     |= cx[k];
        y0     |= cy[k];
        hit    |= cf[k].eq;
        at_end |= last[k];
      end
      if (k + 1 < MAX_NODES && sel[k]) begin
        x1 |= cx[(k + 1) % MAX_NODES];
        y1 |= cy[(k + 1) % MAX_NODES];
      end
    end
  end

  // Operands for interpolation; offset and span fit 32 bits unsigned.
  logic signed [CoordW:0] dy;
  logic [CoordW:0] mag, off_w, dx_w;
  assign dy    = (CoordW + 1)'(y1) - (CoordW + 1)'(y0);
  assign mag   = dy[CoordW] ? (CoordW + 1)'(-dy) : dy;
  assign off_w = (CoordW + 1)'(x_coord_i) - (CoordW + 1)'(x0);
  assign dx_w  = (CoordW + 1)'(x1) - (CoordW + 1)'(x0);

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    result_d    = result_q;
    ins_en      = 1'b0;
    md_start    = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (md_done) begin
      // Deliver the interpolated value.
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      result_d    = md_result;
    end
    if (accept) begin
      status_d    = ST_OK;
      result_d    = '0;
      out_valid_d = 1'b1;
      unique case (cmd_e'(cmd_i))
        CMD_CLEAR: count_d = '0;
        CMD_INSERT: begin
          if (dup) begin
            status_d = ST_DUP;
          end else if (count_q >= MaxCnt) begin
            status_d = ST_FULL;
          end else begin
            ins_en  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        CMD_QUERY: begin
          if (count_q == '0 || !cf[0].le || above) begin
            status_d = ST_OOR;
          end else if (hit || at_end) begin
            result_d = y0;
          end else begin
            // Hold the result back until the arithmetic unit finishes.
            out_valid_d = 1'b0;
            busy_d      = 1'b1;
            md_start    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  pli_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .mag_i    (mag),
    .neg_i    (dy[CoordW]),
    .off_i    (off_w[CoordW-1:0]),
    .dx_i     (dx_w[CoordW-1:0]),
    .y0_i     (y0),
    .busy_o   (md_busy),
    .done_o   (md_done),
    .result_o (md_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    result_q <= result_d;
  end

  logic [CntW+TotalW-1:0] total_w;
  assign total_w        = (CntW + TotalW)'(count_q);
  assign node_total_o   = total_w[TotalW-1:0];
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("node count above table size");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && out_valid_q)) else $error("result shown while interpolating");
  a_unit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_busy |-> busy_q) else $error("arithmetic unit running without a request");
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> $past(busy_q)) else $error("unexpected arithmetic completion");
endmodule

FILE: dv/pli_checker.sv
// Checker: watches both channels, predicts each result of the interpolator and compares.
`timescale 1ns / 1ps
module pli_checker
  import pli_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               cmd_i,
  input  logic signed [CoordW-1:0] x_coord_i,
  input  logic signed [CoordW-1:0] y_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               status_i,
  input  logic signed [CoordW-1:0] result_value_i,
  input  logic [TotalW-1:0]        node_total_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    status_e                   status;
    logic signed [CoordW-1:0]  value;
    logic [TotalW-1:0]         total;
  } outcome_t;

  outcome_t                 due_q[$];
  logic signed [CoordW-1:0] tab_x[MAX_NODES];
  logic signed [CoordW-1:0] tab_y[MAX_NODES];
  int unsigned              tab_n;

  assign pending_o = due_q.size();

  task automatic report(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  // Product first, unsigned division truncates the magnitude, then saturate.
  function automatic logic signed [CoordW-1:0] blend(int unsigned seg,
                                                     logic signed [CoordW-1:0] x);
    longint          x0, x1, y0, y1, dy, s;
    longint unsigned off, dx, mag, q;
    x0  = tab_x[seg];
    x1  = tab_x[seg+1];
    y0  = tab_y[seg];
    y1  = tab_y[seg+1];
    dy  = y1 - y0;
    off = longint'(x) - x0;
    dx  = x1 - x0;
    mag = (dy < 0) ? -dy : dy;
    q   = (mag * off) / dx;
    s   = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[CoordW-1:0];
  endfunction

  function automatic outcome_t apply_request(cmd_e c, logic signed [CoordW-1:0] x,
                                             logic signed [CoordW-1:0] y);
    outcome_t    o;
    logic        dup;
    int unsigned pos, seg;
    o = '{status: ST_OK, value: '0, total: '0};
    case (c)
      CMD_CLEAR: begin
        tab_n = 0;
      end
      CMD_INSERT: begin
        dup = 1'b0;
        for (int unsigned i = 0; i < tab_n; i++) if (tab_x[i] == x) dup = 1'b1;
        if (dup) begin
          o.status = ST_DUP;
        end else if (tab_n >= MAX_NODES) begin
          o.status = ST_FULL;
        end else begin
          pos = tab_n;
          while (pos > 0 && tab_x[pos-1] > x) begin
            tab_x[pos] = tab_x[pos-1];
            tab_y[pos] = tab_y[pos-1];
            pos--;
          end
          tab_x[pos] = x;
          tab_y[pos] = y;
          tab_n++;
        end
      end
      CMD_QUERY: begin
        if (tab_n == 0 || x < tab_x[0] || x > tab_x[tab_n-1]) begin
          o.status = ST_OOR;
        end else begin
          seg = 0;
          for (int unsigned i = 0; i < tab_n; i++) if (tab_x[i] <= x) seg = i;
          if (tab_x[seg] == x || seg + 1 >= tab_n) o.value = tab_y[seg];
          else o.value = blend(seg, x);
        end
      end
      default: ;
    endcase
    o.total = tab_n[TotalW-1:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      tab_n = 0;
      due_q.delete();
    end else begin
      // Compare an outgoing result before queuing a request taken in the same edge.
      if (out_valid_i && out_ready_i) begin
        got = '{status: status_e'(status_i), value: result_value_i, total: node_total_i};
        if (due_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = due_q.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.value != want.value)
            report($sformatf("value %0d, want %0d", got.value, want.value));
          if (got.total != want.total)
            report($sformatf("node_total %0d, want %0d", got.total, want.total));
        end
      end
      if (in_valid_i && in_ready_i)
        due_q = {due_q, apply_request(cmd_e'(cmd_i), x_coord_i, y_value_i)};
    end
  end

  initial fail_count_o = 0;

endmodule

FILE: dv/tb_piecewise_linear_interpolator_core.sv
// Testbench top: stimulus, handshake pacing and verdict for the interpolator core.
`timescale 1ns / 1ps
module tb_piecewise_linear_interpolator_core
  import pli_pkg::*;
();

  localparam int unsigned Nodes     = MaxNodesDef;
  localparam int          StallCap  = 6000;
  localparam int          HoldSpan  = 400;
  localparam int          RandItems = 1880;

  logic                     clk_i, rst_ni;
  logic                     in_valid_i, in_ready_o;
  logic [1:0]               cmd_i;
  logic signed [CoordW-1:0] x_coord_i, y_value_i;
  logic                     out_valid_o, out_ready_i;
  logic [1:0]               status_o;
  logic signed [CoordW-1:0] result_value_o;
  logic [TotalW-1:0]        node_total_o;
  int                       fail_count, pending;

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int          idle_mode;
  logic        hold_go, hold_done;
  int          quiet_cycles;
  int          sent;
  longint      xs[$];

  piecewise_linear_interpolator_core #(.MAX_NODES(Nodes)) dut (.*);

  pli_checker #(.MAX_NODES(Nodes)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .x_coord_i,
    .y_value_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .result_value_i(result_value_o), .node_total_i(node_total_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure per mode, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready_i = 1'b0;
        repeat (HoldSpan) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (idle_mode == 2) out_ready_i = ($urandom_range(99) >= 52);
      else if (idle_mode == 3) out_ready_i = ($urandom_range(99) >= 20);
      else out_ready_i = 1'b1;
    end
  end

  // Watchdog: abort when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallCap) begin
      $display("** piecewise_linear_interpolator_core: FAILED **");
      $finish;
    end
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic send(input cmd_e c, input longint x, input longint y);
    int gap;
    gap = 0;
    if (idle_mode == 1 && $urandom_range(99) < 52) gap = $urandom_range(1, 4);
    if (idle_mode == 3 && $urandom_range(99) < 20) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i      = c;
    x_coord_i  = x[CoordW-1:0];
    y_value_i  = y[CoordW-1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    // Track the abscissas held, for steering queries into the span.
    if (c == CMD_CLEAR) xs.delete();
    if (c == CMD_INSERT && xs.size() < Nodes && !(x inside {xs})) xs = {xs, x};
  endtask

  function automatic longint rand_word();
    return longint'($signed($urandom()));
  endfunction

  // Argument between two held nodes, ends included.
  function automatic longint span_arg();
    longint          a, b, lo, hi;
    longint unsigned r;
    a  = xs[$urandom_range(xs.size() - 1)];
    b  = xs[$urandom_range(xs.size() - 1)];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    r  = {$urandom(), $urandom()};
    return lo + longint'(r % unsigned'(hi - lo + 1));
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int n_ins, n_q, pick;
    in_valid_i = 1'b0;
    cmd_i      = CMD_CLEAR;
    x_coord_i  = '0;
    y_value_i  = '0;
    hold_go    = 1'b0;
    idle_mode  = 0;
    sent       = 0;
    rst_ni     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, unused code, extreme nodes, node hits, dup, full.
    send(CMD_QUERY, 0, 0);
    send(CMD_NONE, 123, 456);
    send(CMD_INSERT, -64'sd2147483648, 64'sd2147483647);
    send(CMD_INSERT, 64'sd2147483647, -64'sd2147483648);
    send(CMD_QUERY, -64'sd2147483648, 0);
    send(CMD_QUERY, 64'sd2147483647, 0);
    send(CMD_QUERY, 0, 0);
    send(CMD_QUERY, -1, 0);
    send(CMD_INSERT, 0, 32'h0001_0000);
    send(CMD_QUERY, 0, 0);
    send(CMD_INSERT, 0, 5);
    send(CMD_CLEAR, 0, 0);
    send(CMD_QUERY, 5, 0);
    for (int i = 0; i < Nodes; i++) send(CMD_INSERT, (Nodes - i) * 1000, rand_word());
    send(CMD_INSERT, 99, 1);
    send(CMD_INSERT, 3000, 1);
    send(CMD_QUERY, 999, 0);
    send(CMD_QUERY, 16001, 0);
    send(CMD_QUERY, 16000, 0);
    send(CMD_QUERY, 1500, 0);

    // Fill up the block behind a long receiver hold-off, then settle.
    hold_go = 1'b1;
    repeat (6) send(CMD_QUERY, $urandom_range(1000, 16000), 0);
    drain();

    // Random: well-formed tables with random content, queries, noise.
    while (sent < RandItems) begin
      idle_mode = (sent / 380) % 4;
      send(CMD_CLEAR, rand_word(), rand_word());
      n_ins = $urandom_range(2, Nodes + 2);
      for (int i = 0; i < n_ins; i++) begin
        if (xs.size() > 0 && $urandom_range(9) == 0)
          send(CMD_INSERT, xs[$urandom_range(xs.size() - 1)], rand_word());
        else if ($urandom_range(3) == 0)
          send(CMD_INSERT, longint'($signed(16'($urandom()))), rand_word());
        else
          send(CMD_INSERT, rand_word(), rand_word());
      end
      n_q = $urandom_range(3, 10);
      for (int i = 0; i < n_q; i++) begin
        pick = $urandom_range(19);
        if (xs.size() == 0 || pick == 0) send(CMD_QUERY, rand_word(), rand_word());
        else if (pick < 4) send(CMD_QUERY, xs[$urandom_range(xs.size() - 1)], 0);
        else if (pick == 4) send(CMD_NONE, rand_word(), rand_word());
        else send(CMD_QUERY, span_arg(), rand_word());
      end
      if ($urandom_range(15) == 0) drain();
    end

    drain();
    repeat (150) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** piecewise_linear_interpolator_core: PASSED **");
    end else begin
      if (pending != 0) $display("ERROR: %0d results never arrived", pending);
      $display("** piecewise_linear_interpolator_core: FAILED **");
    end
    $finish;
  end

  initial quiet_cycles = 0;

endmodule
